// ===== rtl/core/sbrc_pkg.sv =====
// Shared constants, codes and types of the sixteen-bit RISC core step block.
package sbrc_pkg;

  // Word memory geometry (power of two, 128 to 8192 words)
  localparam int MEM_WORDS = 8192;
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  // Datapath widths
  localparam int WORD_W   = 16;
  localparam int REG_AW   = 3;
  localparam int REGS     = 8;
  localparam int OP_W     = 2;
  localparam int ADDR_W   = 13;
  localparam int IMM13_W  = 13;

  // Stream payload widths
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 40;

  // Fixed register numbers
  localparam logic [REG_AW-1:0] LINK_REG = 3'd7;
  localparam logic [REG_AW-1:0] ZERO_REG = 3'd0;

  // Sign fill for the 7-bit immediate
  localparam logic [WORD_W-1:0] IMM7_EXTEND = 16'hFF80;

  // Item operations
  typedef enum logic [OP_W-1:0] {
    OP_MWRITE = 2'd0,
    OP_EXEC   = 2'd1,
    OP_MREAD  = 2'd2,
    OP_RREAD  = 2'd3
  } op_t;

  // Instruction formats, top three bits
  typedef enum logic [2:0] {
    FMT_REG  = 3'd0,
    FMT_ADDI = 3'd1,
    FMT_J    = 3'd2,
    FMT_JAL  = 3'd3,
    FMT_LW   = 3'd4,
    FMT_SW   = 3'd5,
    FMT_JEQ  = 3'd6,
    FMT_SLTI = 3'd7
  } fmt_t;

  // Three-register function codes
  localparam logic [3:0] FN_ADD = 4'h0;
  localparam logic [3:0] FN_SUB = 4'h1;
  localparam logic [3:0] FN_OR  = 4'h2;
  localparam logic [3:0] FN_AND = 4'h3;
  localparam logic [3:0] FN_SLT = 4'h4;
  localparam logic [3:0] FN_JR  = 4'h8;

  // Engine states, one-hot
  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_FINISH = 6'b000100,
    S_DECODE = 6'b001000,
    S_EXEC   = 6'b010000,
    S_LOAD   = 6'b100000
  } state_t;

  // Sign-extend the 7-bit immediate of an instruction
  function automatic logic [WORD_W-1:0] imm7_sext(input logic [WORD_W-1:0] ins);
    logic [WORD_W-1:0] v;
    v = {9'd0, ins[6:0]};
    if (ins[6]) v = v | IMM7_EXTEND;
    return v;
  endfunction

endpackage

// ===== rtl/core/sixteen_bit_risc_core_step_top.sv =====
// Sixteen-bit RISC core step block: word memory, register file and step engine.
//
//  channel | dir | fields (low bit first)                             | handshake
//  --------+-----+----------------------------------------------------+-------------------
//  s_*     | in  | opcode[1:0] address[14:2] write_data[30:15], 0 pad | s_tvalid / s_tready
//  m_*     | out | pc[15:0] halted[16] read_data[32:17], 0 pad        | m_tvalid / m_tready
//
// Memory write, memory read, register read and an execute on a halted core pass through idle
// and finish; an execute passes through idle (fetch read), decode (register read) and exec
// (compute), and a load adds a load state after the load read that exec issues (the single
// word memory port and the registered reads set this). After reset a clearing pass zeroes all
// MEM_WORDS (8192) words; s_tready stays low meanwhile. An input register takes the next item
// while the engine works, and a full output register holds the engine in its last step until m_tready.
module sixteen_bit_risc_core_step_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // opcode, address, write_data, zero pad
  input  logic [sbrc_pkg::S_DATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // pc, halted, read_data, zero pad
  output logic [sbrc_pkg::M_DATA_W-1:0] m_tdata
);
  import sbrc_pkg::*;

  // Input holding register
  logic              hold_valid;
  op_t               hold_op;
  logic [ADDR_W-1:0] hold_addr;
  logic [WORD_W-1:0] hold_wdata;

  // Item in the engine
  op_t               cur_op;
  logic [ADDR_W-1:0] cur_addr;
  logic [WORD_W-1:0] cur_wdata;

  state_t            state, state_next;
  logic [MEM_AW-1:0] clr_cnt;

  // Architectural state
  logic [WORD_W-1:0] pc, pc_next;
  logic              halted, halted_next;
  logic [WORD_W-1:0] ins;
  logic              ins_load;

  // Word memory
  logic [WORD_W-1:0] mem [MEM_WORDS];
  logic              mem_we, mem_re;
  logic [MEM_AW-1:0] mem_wa, mem_ra;
  logic [WORD_W-1:0] mem_wd, mem_q;

  // Register file
  logic [WORD_W-1:0] regs [REGS];
  logic [REGS-1:0]   reg_vld;
  logic              reg_we, reg_re;
  logic [REG_AW-1:0] reg_wa, reg_ra_a, reg_ra_b;
  logic [WORD_W-1:0] reg_wd, reg_qa, reg_qb;

  // Result
  logic              out_free, fin, take;
  logic [WORD_W-1:0] res_rd;

  // Decoded instruction fields
  fmt_t              fmt;
  logic [3:0]        func;
  logic [WORD_W-1:0] imm, imm13, pc_inc, ea;

  assign s_tready = !hold_valid && (state != S_CLEAR);
  assign out_free = !m_tvalid || m_tready;

  assign fmt    = fmt_t'(ins[15:13]);
  assign func   = ins[3:0];
  assign imm    = imm7_sext(ins);
  assign imm13  = {{(WORD_W-IMM13_W){1'b0}}, ins[IMM13_W-1:0]};
  assign pc_inc = pc + 16'd1;
  assign ea     = reg_qa + imm;

  // Hold one item ahead of the engine
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold_op    <= op_t'(s_tdata[1:0]);
      hold_addr  <= s_tdata[14:2];
      hold_wdata <= s_tdata[30:15];
    end
    if (take) begin
      cur_op    <= hold_op;
      cur_addr  <= hold_addr;
      cur_wdata <= hold_wdata;
    end
    if (ins_load) ins <= mem_q;
  end

  // Engine control: issue reads, compute, write back
  always_comb begin
    state_next  = state;
    take        = 1'b0;
    fin         = 1'b0;
    ins_load    = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = clr_cnt;
    mem_wd      = '0;
    mem_re      = 1'b0;
    mem_ra      = hold_addr[MEM_AW-1:0];
    reg_re      = 1'b0;
    reg_ra_a    = hold_addr[REG_AW-1:0];
    reg_ra_b    = ins[9:7];
    reg_we      = 1'b0;
    reg_wa      = ins[9:7];
    reg_wd      = '0;
    pc_next     = pc;
    res_rd      = '0;

    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_cnt == MEM_AW'(MEM_WORDS - 1)) state_next = S_IDLE;
      end

      S_IDLE: begin
        if (hold_valid) begin
          take       = 1'b1;
          state_next = S_FINISH;
          case (hold_op)
            OP_EXEC: begin
              if (!halted) begin
                mem_re     = 1'b1;
                mem_ra     = pc[MEM_AW-1:0];
                state_next = S_DECODE;
              end
            end
            OP_MREAD: mem_re = 1'b1;
            OP_RREAD: reg_re = 1'b1;
            default: ;
          endcase
        end
      end

      S_FINISH: begin
        if (out_free) begin
          fin        = 1'b1;
          state_next = S_IDLE;
          case (cur_op)
            OP_MWRITE: begin
              mem_we = 1'b1;
              mem_wa = cur_addr[MEM_AW-1:0];
              mem_wd = cur_wdata;
            end
            OP_MREAD: res_rd = mem_q;
            OP_RREAD: res_rd = reg_qa;
            default: ;
          endcase
        end
      end

      S_DECODE: begin
        ins_load   = 1'b1;
        reg_re     = 1'b1;
        reg_ra_a   = mem_q[12:10];
        reg_ra_b   = mem_q[9:7];
        state_next = S_EXEC;
      end

      S_EXEC: begin
        if (fmt == FMT_LW) begin
          mem_re     = 1'b1;
          mem_ra     = ea[MEM_AW-1:0];
          state_next = S_LOAD;
        end else if (out_free) begin
          fin        = 1'b1;
          state_next = S_IDLE;
          pc_next    = pc_inc;
          case (fmt)
            FMT_REG: begin
              reg_wa = ins[6:4];
              case (func)
                FN_ADD: begin reg_we = 1'b1; reg_wd = reg_qa + reg_qb; end
                FN_SUB: begin reg_we = 1'b1; reg_wd = reg_qa - reg_qb; end
                FN_OR:  begin reg_we = 1'b1; reg_wd = reg_qa | reg_qb; end
                FN_AND: begin reg_we = 1'b1; reg_wd = reg_qa & reg_qb; end
                FN_SLT: begin
                  reg_we = 1'b1;
                  reg_wd = {{(WORD_W-1){1'b0}}, reg_qa < reg_qb};
                end
                FN_JR:  pc_next = reg_qa;
                default: ;
              endcase
            end
            FMT_ADDI: begin reg_we = 1'b1; reg_wd = ea; end
            FMT_J:    pc_next = imm13;
            FMT_JAL: begin
              reg_we  = 1'b1;
              reg_wa  = LINK_REG;
              reg_wd  = pc_inc;
              pc_next = imm13;
            end
            FMT_SW: begin
              mem_we = 1'b1;
              mem_wa = ea[MEM_AW-1:0];
              mem_wd = reg_qb;
            end
            FMT_JEQ: if (reg_qa == reg_qb) pc_next = pc_inc + imm;
            FMT_SLTI: begin
              reg_we = 1'b1;
              reg_wd = {{(WORD_W-1){1'b0}}, reg_qa < imm};
            end
            default: ;
          endcase
        end
      end

      S_LOAD: begin
        if (out_free) begin
          fin        = 1'b1;
          state_next = S_IDLE;
          pc_next    = pc_inc;
          reg_we     = 1'b1;
          reg_wd     = mem_q;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // Register zero is never written
    if (reg_wa == ZERO_REG) reg_we = 1'b0;
    if (state == S_FINISH) halted_next = halted;
    else halted_next = halted || (fin && (pc_next == pc));
  end

  // Advance engine, pc and halt flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      pc      <= '0;
      halted  <= 1'b0;
    end else begin
      state  <= state_next;
      pc     <= pc_next;
      halted <= halted_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + MEM_AW'(1);
    end
  end

  // Word memory: one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_ra];
  end

  // Register file: two registered reads, unwritten entries read zero
  always_ff @(posedge clk) begin
    if (reg_we) regs[reg_wa] <= reg_wd;
    if (reg_re) begin
      reg_qa <= reg_vld[reg_ra_a] ? regs[reg_ra_a] : '0;
      reg_qb <= reg_vld[reg_ra_b] ? regs[reg_ra_b] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_vld <= '0;
    end else if (reg_we) begin
      reg_vld[reg_wa] <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      m_tdata <= {{(M_DATA_W-2*WORD_W-1){1'b0}}, res_rd, halted_next, pc_next};
    end
  end

  // Checks
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !s_tready)
    else $error("item accepted during memory clearing pass");

  a_one_mem_access: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("word memory read and written in one cycle");

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt flag cleared");

  a_no_zero_write: assert property (@(posedge clk) disable iff (rst)
    reg_we |-> reg_wa != ZERO_REG)
    else $error("register zero written");

  a_fin_needs_room: assert property (@(posedge clk) disable iff (rst)
    fin |-> out_free)
    else $error("result produced into a full output register");

endmodule

// ===== sim/testbench.sv =====
// Testbench for the sixteen-bit RISC core step block: stream driver, monitor and predictor.
`timescale 1ns / 100ps

module testbench;
  import sbrc_pkg::*;

  // Reg-format function with no defined effect
  localparam logic [3:0] FN_UNUSED = 4'hF;
  // Cycles with no handshake before the run is abandoned (covers the clearing pass)
  localparam int IDLE_LIMIT = MEM_WORDS + 6000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS = 1540;

  // One input item, opcode in the low bits
  typedef struct packed {
    logic [15:0] wdata;
    logic [12:0] addr;
    op_t         op;
  } cmd_t;

  // One result item, pc in the low bits
  typedef struct packed {
    logic [15:0] rdata;
    logic        halted;
    logic [15:0] pc;
  } core_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  // Core state: copy 0 follows accepted items, copy 1 runs ahead with the stimulus
  logic [15:0] mem_st [0:1][0:MEM_WORDS-1];
  logic [15:0] regs_st [0:1][0:7];
  logic [15:0] pc_st [0:1];
  logic        halt_st [0:1];

  cmd_t      cmds_to_send [$];
  core_out_t due_readouts [$];

  int n_total = 0;
  int n_out = 0;
  int errors = 0;
  int idle_cycles = 0;
  int op_count [0:3] = '{0, 0, 0, 0};
  int in_gap = 0;
  int out_stall = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  logic in_taken = 1'b0;

  sixteen_bit_risc_core_step_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  function automatic logic [15:0] sext7(logic [6:0] v);
    return {{9{v[6]}}, v};
  endfunction

  function automatic void set_reg(int k, logic [2:0] r, logic [15:0] v);
    if (r != ZERO_REG) regs_st[k][r] = v;
  endfunction

  // Where the instruction at the current pc sends the pc
  function automatic logic [15:0] next_pc(int k);
    logic [15:0] ins;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] nxt;
    ins = mem_st[k][pc_st[k] % MEM_WORDS];
    a = regs_st[k][ins[12:10]];
    b = regs_st[k][ins[9:7]];
    nxt = pc_st[k] + 16'd1;
    case (ins[15:13])
      FMT_REG: if (ins[3:0] == FN_JR) nxt = a;
      FMT_J, FMT_JAL: nxt = {3'b000, ins[12:0]};
      FMT_JEQ: if (a == b) nxt = nxt + sext7(ins[6:0]);
      default: ;
    endcase
    return nxt;
  endfunction

  // Execute the instruction at the pc
  function automatic void step_core(int k);
    logic [15:0] ins;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] imm;
    logic [15:0] ea;
    logic [15:0] prev;
    logic [15:0] nxt;
    prev = pc_st[k];
    ins = mem_st[k][prev % MEM_WORDS];
    a = regs_st[k][ins[12:10]];
    b = regs_st[k][ins[9:7]];
    imm = sext7(ins[6:0]);
    ea = a + imm;
    nxt = next_pc(k);
    case (ins[15:13])
      FMT_REG: begin
        case (ins[3:0])
          FN_ADD: set_reg(k, ins[6:4], a + b);
          FN_SUB: set_reg(k, ins[6:4], a - b);
          FN_OR:  set_reg(k, ins[6:4], a | b);
          FN_AND: set_reg(k, ins[6:4], a & b);
          FN_SLT: set_reg(k, ins[6:4], (a < b) ? 16'd1 : 16'd0);
          default: ;
        endcase
      end
      FMT_ADDI: set_reg(k, ins[9:7], ea);
      FMT_JAL:  set_reg(k, LINK_REG, prev + 16'd1);
      FMT_LW:   set_reg(k, ins[9:7], mem_st[k][ea % MEM_WORDS]);
      FMT_SW:   mem_st[k][ea % MEM_WORDS] = b;
      FMT_SLTI: set_reg(k, ins[9:7], (a < imm) ? 16'd1 : 16'd0);
      default: ;
    endcase
    pc_st[k] = nxt;
    if (nxt == prev) halt_st[k] = 1'b1;
  endfunction

  // Apply one item to a state copy and return the result it produces
  function automatic core_out_t core_apply(int k, cmd_t c);
    core_out_t o;
    o = '0;
    case (c.op)
      OP_MWRITE: mem_st[k][c.addr % MEM_WORDS] = c.wdata;
      OP_EXEC:   if (!halt_st[k]) step_core(k);
      OP_MREAD:  o.rdata = mem_st[k][c.addr % MEM_WORDS];
      default:   o.rdata = regs_st[k][c.addr[2:0]];
    endcase
    o.pc = pc_st[k];
    o.halted = halt_st[k];
    return o;
  endfunction

  function automatic logic [15:0] enc_reg(logic [2:0] ra, logic [2:0] rb, logic [2:0] rc,
                                          logic [3:0] fn);
    return {FMT_REG, ra, rb, rc, fn};
  endfunction

  function automatic logic [15:0] enc_imm(fmt_t fmt, logic [2:0] ra, logic [2:0] rb,
                                          logic [6:0] imm);
    return {fmt, ra, rb, imm};
  endfunction

  function automatic logic [15:0] enc_jump(fmt_t fmt, logic [12:0] target);
    return {fmt, target};
  endfunction

  function automatic logic [15:0] rand_ins();
    fmt_t fmt;
    logic [3:0] fn;
    fmt = fmt_t'($urandom_range(0, 7));
    if (fmt == FMT_REG) begin
      case ($urandom_range(0, 11))
        0, 1: fn = FN_ADD;
        2: fn = FN_SUB;
        3: fn = FN_OR;
        4: fn = FN_AND;
        5, 6: fn = FN_SLT;
        7: fn = FN_JR;
        default: fn = 4'($urandom_range(0, 15));
      endcase
      return enc_reg(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                     3'($urandom_range(0, 7)), fn);
    end
    if (fmt == FMT_J || fmt == FMT_JAL)
      return enc_jump(fmt, 13'($urandom_range(0, 8191)));
    return enc_imm(fmt, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                   7'($urandom_range(0, 127)));
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Queue one item and advance the look-ahead copy
  task automatic put(op_t op, logic [12:0] addr, logic [15:0] data);
    cmd_t c;
    c.op = op;
    c.addr = addr;
    c.wdata = data;
    cmds_to_send.push_back(c);
    void'(core_apply(1, c));
    n_total++;
  endtask

  task automatic run_ins(logic [15:0] ins);
    put(OP_MWRITE, 13'(pc_st[1] % MEM_WORDS), ins);
    put(OP_EXEC, 13'($urandom_range(0, 8191)), 16'($urandom_range(0, 65535)));
  endtask

  // Drive input items at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        s_tvalid <= 1'b0;
      end else if (cmds_to_send.size() > 0) begin
        s_tdata <= S_DATA_W'(cmds_to_send.pop_front());
        s_tvalid <= 1'b1;
        if ($urandom_range(0, 199) == 0) in_calm = ~in_calm;
        in_gap = pick_gap(in_calm);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) out_calm = ~out_calm;
    if (out_stall == 0 && !out_calm && $urandom_range(0, 3) == 0)
      out_stall = pick_gap(1'b0);
    if (out_stall > 0) begin
      out_stall--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Predict on accepted items, check accepted results, watch for a stuck run
  always @(posedge clk) begin
    cmd_t c;
    core_out_t want;
    core_out_t got;
    in_taken <= s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        c = cmd_t'(s_tdata[30:0]);
        due_readouts.push_back(core_apply(0, c));
        op_count[c.op]++;
      end
      if (m_tvalid && m_tready) begin
        got = core_out_t'(m_tdata[32:0]);
        n_out++;
        if (due_readouts.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, got pc %h halted %b read %h",
                   $time, got.pc, got.halted, got.rdata);
        end else begin
          want = due_readouts.pop_front();
          if (got.pc !== want.pc) begin
            errors++;
            $display("%0t: pc mismatch, expected %h, got %h", $time, want.pc, got.pc);
          end
          if (got.halted !== want.halted) begin
            errors++;
            $display("%0t: halted mismatch, expected %b, got %b",
                     $time, want.halted, got.halted);
          end
          if (got.rdata !== want.rdata) begin
            errors++;
            $display("%0t: read_data mismatch, expected %h, got %h",
                     $time, want.rdata, got.rdata);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int r;
    logic [12:0] a;
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < MEM_WORDS; i++) mem_st[k][i] = '0;
      for (int i = 0; i < 8; i++) regs_st[k][i] = '0;
      pc_st[k] = '0;
      halt_st[k] = 1'b0;
    end

    // Directed program: each instruction format except FMT_J, register zero, address and pc wrap
    run_ins(enc_imm(FMT_ADDI, 3'd0, 3'd1, 7'h7F));
    run_ins(enc_imm(FMT_ADDI, 3'd0, 3'd2, 7'h3F));
    run_ins(enc_reg(3'd1, 3'd2, 3'd3, FN_ADD));
    run_ins(enc_reg(3'd2, 3'd1, 3'd4, FN_SLT));
    run_ins(enc_reg(3'd1, 3'd2, 3'd5, FN_UNUSED));
    run_ins(enc_imm(FMT_ADDI, 3'd1, 3'd0, 7'h05));
    run_ins(enc_imm(FMT_SW, 3'd2, 3'd1, 7'h40));
    run_ins(enc_imm(FMT_LW, 3'd0, 3'd6, 7'h7F));
    run_ins(enc_imm(FMT_SLTI, 3'd2, 3'd5, 7'h7F));
    run_ins(enc_imm(FMT_JEQ, 3'd0, 3'd0, 7'h3F));
    run_ins(enc_jump(FMT_JAL, 13'h1FFF));
    run_ins(enc_reg(3'd1, 3'd0, 3'd0, FN_JR));
    run_ins(enc_reg(3'd1, 3'd2, 3'd3, FN_OR));
    put(OP_RREAD, 13'h1FF8, 16'hFFFF);
    put(OP_RREAD, 13'h1FFF, 16'h0000);
    put(OP_MREAD, 13'h1FFF, 16'hFFFF);
    put(OP_MWRITE, 13'h0000, 16'hFFFF);
    put(OP_MREAD, 13'h0000, 16'h0000);

    // Random programs written at the pc and stepped, mixed with plain accesses
    while (n_total < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      a = 13'((pc_st[1] + $urandom_range(0, 7)) % MEM_WORDS);
      if ($urandom_range(0, 1) == 0) a = 13'($urandom_range(0, 8191));
      if (r < 62) begin
        if ($urandom_range(0, 3) != 0)
          put(OP_MWRITE, 13'(pc_st[1] % MEM_WORDS), rand_ins());
        // keep the core running until the closing part
        while (next_pc(1) == pc_st[1])
          put(OP_MWRITE, 13'(pc_st[1] % MEM_WORDS), rand_ins());
        put(OP_EXEC, 13'($urandom_range(0, 8191)), 16'($urandom_range(0, 65535)));
      end else if (r < 77) begin
        put(OP_MWRITE, a, ($urandom_range(0, 1) == 0) ? rand_ins()
                                                      : 16'($urandom_range(0, 65535)));
      end else if (r < 88) begin
        put(OP_MREAD, a, 16'($urandom_range(0, 65535)));
      end else begin
        put(OP_RREAD, 13'($urandom_range(0, 8191)), 16'($urandom_range(0, 65535)));
      end
    end

    // Close with a self branch: the core halts and stays halted
    run_ins(enc_imm(FMT_JEQ, 3'd3, 3'd3, 7'h7F));
    put(OP_EXEC, 13'h1FFF, 16'hFFFF);
    put(OP_MWRITE, 13'(pc_st[1] % MEM_WORDS), enc_reg(3'd1, 3'd2, 3'd3, FN_ADD));
    put(OP_EXEC, 13'h0000, 16'h0000);
    put(OP_MREAD, 13'(pc_st[1] % MEM_WORDS), 16'h0000);
    put(OP_RREAD, 13'h0007, 16'h0000);

    // Reset, then wait for every result
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    while (n_out < n_total) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d items: %0d executes, %0d memory writes, %0d memory reads, %0d register reads",
             n_total, op_count[OP_EXEC], op_count[OP_MWRITE], op_count[OP_MREAD],
             op_count[OP_RREAD]);
    $display("Checked %0d results with %0d mismatches; final pc %h, halted %0b",
             n_out, errors, pc_st[0], halt_st[0]);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sbrc_pkg.sv
rtl/core/sixteen_bit_risc_core_step_top.sv
sim/testbench.sv
